>>> sv/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the skyline rectangle allocator.
// ----------------------------------------------------------------------------
package sal_pkg;

   localparam int DEF_SHEET_WIDTH  = 128;
   localparam int DEF_SHEET_HEIGHT = 128;

   localparam int RECT_W   = 8;
   localparam int CORNER_W = 7;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic              op;
      logic [RECT_W-1:0] rect_width;
      logic [RECT_W-1:0] rect_height;
   } req_type;

   typedef struct packed {
      logic                placed;
      logic [CORNER_W-1:0] corner_x;
      logic [CORNER_W-1:0] corner_y;
   } rsp_type;

endpackage

>>> sv/sal_ram.sv
// ----------------------------------------------------------------------------
// sal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sal_engine.sv
// ----------------------------------------------------------------------------
// sal_engine
// Skyline search and update. Column heights live in one RAM; block suffix
// maxima for the sliding-window maximum live in a second RAM. Pass 1 walks
// the columns right to left building suffix maxima within blocks of the
// rectangle width, pass 2 walks left to right with a running prefix maximum;
// window max = max(suffix[i], prefix[i+w-1]). Then the winning span is
// written back one column per cycle.
// ----------------------------------------------------------------------------
module sal_engine #(
   parameter int SHEET_WIDTH  = sal_pkg::DEF_SHEET_WIDTH,
   parameter int SHEET_HEIGHT = sal_pkg::DEF_SHEET_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sal_pkg::req_type start_req,
   output logic             ready,
   input  logic             out_free,
   output logic             done,
   output sal_pkg::rsp_type done_rsp
);
   import sal_pkg::*;

   localparam int XW = $clog2(SHEET_WIDTH);
   localparam int HW = $clog2(SHEET_HEIGHT + 1);
   localparam int SW = ((HW > RECT_W) ? HW : RECT_W) + 1;
   localparam int CW = ((XW > RECT_W) ? XW : RECT_W) + 1;

   localparam logic [XW-1:0] LAST_COL = XW'(SHEET_WIDTH - 1);
   localparam logic [XW-1:0] LAST_WIN = XW'(SHEET_WIDTH - 2);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SUFFIX, ST_TURN, ST_SCAN,
      ST_LAST, ST_CHECK, ST_WRITE, ST_DONE
   } state_type;

   state_type         state_ff;
   logic [XW-1:0]     j_ff;
   logic [XW-1:0]     k_ff;
   logic [XW-1:0]     k0_ff;
   logic [XW-1:0]     w_ff;
   logic [RECT_W-1:0] h_ff;
   logic [XW-1:0]     cnt_ff;
   logic              clr_rsp_ff;

   logic              sb_suf_ff;
   logic              sb_scan_ff;
   logic              sb_rst_ff;
   logic [XW-1:0]     sb_j_ff;
   logic [HW-1:0]     run_ff;

   logic [HW-1:0]     best_base_ff;
   logic [XW-1:0]     best_x_ff;
   logic [HW-1:0]     fill_ff;
   rsp_type           rsp_ff;

   logic [XW-1:0]     wm1;
   logic [CW-1:0]     width_ext;
   logic              reject;
   logic [SW-1:0]     top_sum;

   logic              col_wr_en;
   logic [XW-1:0]     col_wr_addr;
   logic [HW-1:0]     col_wr_data;
   logic [XW-1:0]     col_rd_addr;
   logic [HW-1:0]     col_rd_data;
   logic [XW-1:0]     suf_rd_addr;
   logic [HW-1:0]     suf_rd_data;

   logic [HW-1:0]     run_in;
   logic [HW-1:0]     win_max;
   logic              win_ok;

   assign wm1       = w_ff - XW'(1);
   assign width_ext = CW'(start_req.rect_width);
   assign reject    = (start_req.rect_width == '0) || (start_req.rect_height == '0) ||
                      (width_ext >= CW'(SHEET_WIDTH));
   assign top_sum   = SW'(best_base_ff) + SW'(h_ff);

   // memory ports
   always_comb begin
      col_wr_en   = 1'b0;
      col_wr_addr = j_ff;
      col_wr_data = fill_ff;
      if (state_ff == ST_CLEAR) begin
         col_wr_en   = 1'b1;
         col_wr_data = '0;
      end else if (state_ff == ST_WRITE) begin
         col_wr_en   = 1'b1;
      end
      col_rd_addr = j_ff;
      suf_rd_addr = (j_ff >= wm1) ? (j_ff - wm1) : '0;
   end

   sal_ram #(.WIDTH(HW), .DEPTH(SHEET_WIDTH)) u_col_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_wr_addr),
      .wr_data (col_wr_data),
      .rd_addr (col_rd_addr),
      .rd_data (col_rd_data)
   );

   sal_ram #(.WIDTH(HW), .DEPTH(SHEET_WIDTH)) u_suf_ram (
      .clock   (clock),
      .wr_en   (sb_suf_ff),
      .wr_addr (sb_j_ff),
      .wr_data (run_in),
      .rd_addr (suf_rd_addr),
      .rd_data (suf_rd_data)
   );

   // second stage: running block max and window compare
   always_comb begin
      run_in  = (sb_rst_ff || (col_rd_data > run_ff)) ? col_rd_data : run_ff;
      win_max = (suf_rd_data > run_in) ? suf_rd_data : run_in;
      win_ok  = sb_scan_ff && (sb_j_ff >= wm1) && (sb_j_ff <= LAST_WIN) &&
                (win_max < best_base_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         j_ff       <= '0;
         clr_rsp_ff <= 1'b0;
         sb_suf_ff  <= 1'b0;
         sb_scan_ff <= 1'b0;
      end else begin
         sb_suf_ff  <= (state_ff == ST_SUFFIX);
         sb_scan_ff <= (state_ff == ST_SCAN);
         sb_j_ff    <= j_ff;
         if (sb_suf_ff || sb_scan_ff) begin
            run_ff <= run_in;
         end
         if (win_ok) begin
            best_base_ff <= win_max;
            best_x_ff    <= sb_j_ff - wm1;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               j_ff <= j_ff + XW'(1);
               if (j_ff == LAST_COL) begin
                  state_ff <= clr_rsp_ff ? ST_DONE : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  w_ff   <= XW'(width_ext);
                  h_ff   <= start_req.rect_height;
                  rsp_ff <= '0;
                  k_ff   <= '0;
                  if (start_req.op == OP_CLEAR) begin
                     j_ff       <= '0;
                     clr_rsp_ff <= 1'b1;
                     state_ff   <= ST_CLEAR;
                  end else if (reject) begin
                     state_ff <= ST_DONE;
                  end else begin
                     j_ff     <= LAST_COL;
                     state_ff <= ST_SUFFIX;
                  end
               end
            end
            ST_SUFFIX: begin
               // blocks end (high side) where k is zero
               sb_rst_ff <= (k_ff == '0);
               k_ff      <= (k_ff == wm1) ? '0 : k_ff + XW'(1);
               j_ff      <= j_ff - XW'(1);
               if (j_ff == '0) begin
                  k0_ff    <= k_ff;
                  state_ff <= ST_TURN;
               end
            end
            ST_TURN: begin
               j_ff         <= '0;
               k_ff         <= k0_ff;
               best_base_ff <= HW'(SHEET_HEIGHT);
               best_x_ff    <= '0;
               state_ff     <= ST_SCAN;
            end
            ST_SCAN: begin
               // blocks start (low side) where k is w-1, or at column zero
               sb_rst_ff <= (k_ff == wm1) || (j_ff == '0);
               k_ff      <= (k_ff == '0) ? wm1 : k_ff - XW'(1);
               j_ff      <= j_ff + XW'(1);
               if (j_ff == LAST_COL) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (top_sum > SW'(SHEET_HEIGHT)) begin
                  state_ff <= ST_DONE;
               end else begin
                  fill_ff         <= HW'(top_sum);
                  j_ff            <= best_x_ff;
                  cnt_ff          <= w_ff;
                  rsp_ff.placed   <= 1'b1;
                  rsp_ff.corner_x <= CORNER_W'(best_x_ff);
                  rsp_ff.corner_y <= CORNER_W'(best_base_ff);
                  state_ff        <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               j_ff   <= j_ff + XW'(1);
               cnt_ff <= cnt_ff - XW'(1);
               if (cnt_ff == XW'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign ready    = (state_ff == ST_IDLE);
   assign done     = (state_ff == ST_DONE) && out_free;
   assign done_rsp = rsp_ff;

endmodule

>>> sv/skyline_atlas_allocator_top.sv
// ----------------------------------------------------------------------------
// skyline_atlas_allocator_top
// Skyline bottom-left rectangle allocator with a registered result channel.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports
//  req      in         req_valid, req_stall, req_op, req_rect_width, req_rect_height
//  rsp      out        rsp_valid, rsp_stall, rsp_placed, rsp_corner_x, rsp_corner_y
//
//  Allocate: two sweeps of the column RAM, then one write per spanned column
//  when placed; the two sweeps alone on no room; an invalid request goes
//  straight to the result. Clear: one zeroing pass over the column RAM.
//  After reset a clearing pass zeroes the column RAM; req_stall stays high
//  meanwhile. One transaction is in the engine at a time; a new one is taken
//  while the previous result waits in rsp.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator_top #(
   parameter int SHEET_WIDTH  = sal_pkg::DEF_SHEET_WIDTH,
   parameter int SHEET_HEIGHT = sal_pkg::DEF_SHEET_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [sal_pkg::RECT_W-1:0]     req_rect_width,
   input  logic [sal_pkg::RECT_W-1:0]     req_rect_height,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_placed,
   output logic [sal_pkg::CORNER_W-1:0]   rsp_corner_x,
   output logic [sal_pkg::CORNER_W-1:0]   rsp_corner_y
);
   import sal_pkg::*;

   logic    eng_ready;
   logic    eng_done;
   rsp_type eng_rsp;
   req_type req_in;
   logic    out_free;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign req_in.op          = req_op;
   assign req_in.rect_width  = req_rect_width;
   assign req_in.rect_height = req_rect_height;

   assign req_stall = !eng_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sal_engine #(
      .SHEET_WIDTH  (SHEET_WIDTH),
      .SHEET_HEIGHT (SHEET_HEIGHT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && eng_ready),
      .start_req (req_in),
      .ready     (eng_ready),
      .out_free  (out_free),
      .done      (eng_done),
      .done_rsp  (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= eng_done;
         if (eng_done) begin
            rsp_ff <= eng_rsp;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_placed   = rsp_ff.placed;
   assign rsp_corner_x = rsp_ff.corner_x;
   assign rsp_corner_y = rsp_ff.corner_y;

endmodule

>>> bench/skyline_atlas_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_atlas_allocator_top_test
// Self-checking bench for the skyline rectangle allocator. A local skyline
// model predicts placement and corner of every transaction; results are
// checked in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator_top_test;

   import sal_pkg::*;

   localparam int SHEET_W      = DEF_SHEET_WIDTH;
   localparam int SHEET_H      = DEF_SHEET_HEIGHT;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 3 * SHEET_W + 16;
   localparam int LONG_HOLD    = 2000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_op;
   logic [RECT_W-1:0]   req_rect_width;
   logic [RECT_W-1:0]   req_rect_height;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_placed;
   logic [CORNER_W-1:0] rsp_corner_x;
   logic [CORNER_W-1:0] rsp_corner_y;

   // predictor state: filled height per column
   logic [7:0]          skyline [SHEET_W];
   rsp_type             pending_corners [$];

   int                  error_count    = 0;
   int                  send_idle_pct  = 0;
   int                  recv_idle_pct  = 0;
   int                  rsp_hold       = 0;
   int                  quiet_cycles   = 0;

   skyline_atlas_allocator_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_placed      (rsp_placed),
      .rsp_corner_x    (rsp_corner_x),
      .rsp_corner_y    (rsp_corner_y)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bottom-left skyline placement; updates the local skyline on success, and zeroes it on a clear.
   function automatic rsp_type place_rectangle(logic op, logic [RECT_W-1:0] w,
                                               logic [RECT_W-1:0] h);
      rsp_type res;
      int      width;
      int      best_x;
      int      best_base;
      int      span_max;
      int      i;
      int      j;
      bit      fits;
      res       = '0;
      width     = int'(w);
      best_x    = 0;
      best_base = SHEET_H;
      if (op == OP_CLEAR) begin
         for (i = 0; i < SHEET_W; i++) skyline[i] = '0;
         return res;
      end
      if (w == 0 || h == 0 || width >= SHEET_W) return res;
      // the last start column is never tried
      for (i = 0; i + width < SHEET_W; i++) begin
         span_max = 0;
         fits     = 1'b1;
         for (j = 0; j < width; j++) begin
            if (int'(skyline[i+j]) >= best_base) begin
               fits = 1'b0;
               break;
            end
            if (int'(skyline[i+j]) > span_max) span_max = int'(skyline[i+j]);
         end
         if (fits) begin
            best_x    = i;
            best_base = span_max;
         end
      end
      if (best_base + int'(h) > SHEET_H) return res;
      for (j = 0; j < width; j++) skyline[best_x+j] = 8'(best_base + int'(h));
      res.placed   = 1'b1;
      res.corner_x = best_x[CORNER_W-1:0];
      res.corner_y = best_base[CORNER_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_request(input logic op, input logic [RECT_W-1:0] w,
                               input logic [RECT_W-1:0] h, output rsp_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_rect_width  <= w;
      req_rect_height <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = place_rectangle(op, w, h);
      pending_corners.push_back(want);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_all_results();
      while (pending_corners.size() != 0) @(posedge clock);
   endtask

   task automatic test_field_extremes();
      rsp_type r;
      send_request(OP_CLEAR, 8'hFF, 8'hFF, r);
      send_request(OP_ALLOC, 8'd1, 8'd1, r);
      send_request(OP_ALLOC, 8'd0, 8'd5, r);
      send_request(OP_ALLOC, 8'd5, 8'd0, r);
      send_request(OP_ALLOC, 8'd128, 8'd1, r);
      send_request(OP_ALLOC, 8'hFF, 8'hFF, r);
      send_request(OP_ALLOC, 8'd127, 8'd128, r);
      send_request(OP_CLEAR, 8'd0, 8'd0, r);
      send_request(OP_ALLOC, 8'd127, 8'd127, r);
      // top row only; corner_y at its maximum
      send_request(OP_ALLOC, 8'd1, 8'd1, r);
   endtask

   task automatic test_rightmost_start();
      rsp_type r;
      send_request(OP_CLEAR, 8'h55, 8'hAA, r);
      send_request(OP_ALLOC, 8'd127, 8'd128, r);
      send_request(OP_ALLOC, 8'd1, 8'd1, r);
      send_request(OP_CLEAR, 8'hAA, 8'h55, r);
      send_request(OP_ALLOC, 8'd64, 8'd128, r);
      send_request(OP_ALLOC, 8'd64, 8'd1, r);
      send_request(OP_ALLOC, 8'd63, 8'd129, r);
      send_request(OP_ALLOC, 8'd63, 8'd128, r);
   endtask

   task automatic test_leftmost_tie();
      rsp_type r;
      send_request(OP_CLEAR, 8'd0, 8'd0, r);
      send_request(OP_ALLOC, 8'd3, 8'd10, r);
      send_request(OP_ALLOC, 8'd2, 8'd5, r);
      send_request(OP_ALLOC, 8'd5, 8'd5, r);
      send_request(OP_ALLOC, 8'd10, 8'd1, r);
      send_request(OP_ALLOC, 8'd4, 8'd3, r);
   endtask

   // Mostly small rectangles on a filling sheet; clears after six misses in a row, and at random.
   task automatic test_random_packing(input int count);
      rsp_type r;
      int      n;
      int      pick;
      int      misses;
      logic [RECT_W-1:0] w;
      logic [RECT_W-1:0] h;
      misses = 0;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 4 || misses >= 6) begin
            send_request(OP_CLEAR, RECT_W'($urandom_range(255)),
                         RECT_W'($urandom_range(255)), r);
            misses = 0;
         end else begin
            if (pick < 12) begin
               w = RECT_W'($urandom_range(255));
               h = RECT_W'($urandom_range(255));
            end else if (pick < 22) begin
               w = RECT_W'($urandom_range(127, 20));
               h = RECT_W'($urandom_range(128, 1));
            end else begin
               w = RECT_W'($urandom_range(16, 1));
               h = RECT_W'($urandom_range(24, 1));
            end
            send_request(OP_ALLOC, w, h, r);
            misses = r.placed ? 0 : misses + 1;
         end
      end
   endtask

   // Receiver holds off long enough for the block to fill and stall req.
   task automatic test_result_backpressure();
      rsp_type r;
      int      n;
      rsp_hold = LONG_HOLD;
      for (n = 0; n < 8; n++)
         send_request(OP_ALLOC, RECT_W'($urandom_range(16, 1)),
                      RECT_W'($urandom_range(16, 1)), r);
   endtask

   task automatic test_drain_pause();
      rsp_type r;
      int      n;
      for (n = 0; n < 5; n++)
         send_request(OP_ALLOC, RECT_W'($urandom_range(20, 1)),
                      RECT_W'($urandom_range(20, 1)), r);
      release_request();
      wait_all_results();
      for (n = 0; n < 5; n++)
         send_request(OP_ALLOC, RECT_W'($urandom_range(20, 1)),
                      RECT_W'($urandom_range(20, 1)), r);
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_corners.size() == 0) begin
            report_mismatch("result with no transaction pending", 1, 0);
         end else begin
            want = pending_corners.pop_front();
            if (rsp_placed !== want.placed)
               report_mismatch("placed", int'(rsp_placed), int'(want.placed));
            if (rsp_corner_x !== want.corner_x)
               report_mismatch("corner_x", int'(rsp_corner_x), int'(want.corner_x));
            if (rsp_corner_y !== want.corner_y)
               report_mismatch("corner_y", int'(rsp_corner_y), int'(want.corner_y));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("skyline_atlas_allocator_top_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_ALLOC;
      req_rect_width  = '0;
      req_rect_height = '0;
      for (int c = 0; c < SHEET_W; c++) skyline[c] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 60;
      test_field_extremes();
      test_rightmost_start();
      test_leftmost_tie();
      test_random_packing(430);
      test_result_backpressure();

      send_idle_pct = 60;
      recv_idle_pct = 20;
      test_random_packing(430);
      test_drain_pause();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_packing(430);

      release_request();
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_corners.size() != 0)
         report_mismatch("results never returned", pending_corners.size(), 0);
      if (error_count == 0) begin
         $display("skyline_atlas_allocator_top_test OK");
      end else begin
         $display("skyline_atlas_allocator_top_test NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/sal_pkg.sv
sv/sal_ram.sv
sv/sal_engine.sv
sv/skyline_atlas_allocator_top.sv
bench/skyline_atlas_allocator_top_test.sv
